// ===== rtl/critically_damped_spring_step_core_macros.svh =====
// Assertion helpers for the spring step core.
// Each macro expects clk_i and rst_ni in scope.
`ifndef CRITICALLY_DAMPED_SPRING_STEP_CORE_MACROS_SVH
`define CRITICALLY_DAMPED_SPRING_STEP_CORE_MACROS_SVH

// Same-cycle implication.
`define CSSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spring step check failed");

// Next-cycle implication.
`define CSSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spring step check failed");

`endif

// ===== rtl/csss_pkg.sv =====
package csss_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // Intermediates saturate to +-2^LIM_BITS.
  localparam int LIM_BITS = 60;
  localparam int VAL_W    = LIM_BITS + 2;
  localparam int MAG_W    = LIM_BITS + 1;
  localparam int HALF_W   = 32;
  localparam int PROD_W   = 2 * MAG_W + 1;
  localparam int DIV_W    = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int MUL_STEPS = 4;
  localparam int DT_W     = FRAC_BITS + 1;

  localparam logic [63:0] TWO_LN2_Q32 = 64'd5954088944;
  localparam logic [63:0] C048_Q32    = 64'd2061584302;
  localparam logic [63:0] C0235_Q32   = 64'd1009317315;

  // 2*ln2 scaled by 2^(2*FRAC_BITS) as the dividend for y, rounded.
  localparam logic [127:0] NUM_Y_FULL =
      ((128'(TWO_LN2_Q32) << (2 * FRAC_BITS)) + (128'd1 << 31)) >> 32;
  localparam logic [DIV_W-1:0] NUM_Y = NUM_Y_FULL[DIV_W-1:0];
  localparam logic [DIV_W-1:0] E_NUM = DIV_W'(1) << (2 * FRAC_BITS);

  localparam logic signed [VAL_W-1:0] LIM_V   = VAL_W'(1) << LIM_BITS;
  localparam logic signed [VAL_W-1:0] ONE_V   = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] C048_V  = VAL_W'(C048_Q32);
  localparam logic signed [VAL_W-1:0] C0235_V = VAL_W'(C0235_Q32);
  localparam logic [DT_W-1:0] DT_ONE = DT_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] WORD_MAX =
      VAL_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [VAL_W-1:0] WORD_MIN = -WORD_MAX - VAL_W'(1);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] goal_position;
    logic [DT_W-1:0]             time_step;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] new_position;
    logic signed [WORD_BITS-1:0] new_velocity;
    logic                        clipped;
  } out_t;

  typedef struct packed {
    logic                    start;
    logic                    sh32;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [VAL_W-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic                    sat;
    logic signed [VAL_W-1:0] val;
  } sum_t;

  typedef struct packed {
    logic                        sat;
    logic signed [WORD_BITS-1:0] word;
  } word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_Y, ST_U, ST_U2, ST_U3, ST_DEN, ST_D2, ST_D3, ST_E,
    ST_J0, ST_J1, ST_T, ST_NP, ST_JY, ST_TV, ST_V, ST_NV, ST_WB
  } state_e;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [VAL_W-1:0] a);
    logic signed [VAL_W-1:0] n;
    n = a[VAL_W-1] ? -a : a;
    return n[MAG_W-1:0];
  endfunction

  function automatic sum_t sadd(input logic signed [VAL_W-1:0] a,
                                input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] lim_x;
    sum_t r;
    lim_x = {LIM_V[VAL_W-1], LIM_V};
    s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
    r.sat = 1'b0;
    if (s > lim_x) begin
      r.sat = 1'b1;
      r.val = LIM_V;
    end else if (s < -lim_x) begin
      r.sat = 1'b1;
      r.val = -LIM_V;
    end else begin
      r.val = s[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic word_t to_word(input logic signed [VAL_W-1:0] a);
    word_t r;
    logic signed [VAL_W-1:0] c;
    r.sat = 1'b0;
    c = a;
    if (a > WORD_MAX) begin
      r.sat = 1'b1;
      c = WORD_MAX;
    end else if (a < WORD_MIN) begin
      r.sat = 1'b1;
      c = WORD_MIN;
    end
    r.word = c[WORD_BITS-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/csss_mul.sv =====
// Sign-magnitude multiplier: four 32x32 partial products, then round and clamp.
module csss_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csss_pkg::mul_req_t req_i,
  output csss_pkg::mul_rsp_t rsp_o
);

  logic [csss_pkg::MAG_W-1:0]        a_q, b_q;
  logic                              neg_q, sh32_q;
  logic                              busy_q, done_q, sat_q;
  logic [2:0]                        cnt_q;
  logic [csss_pkg::PROD_W-1:0]       acc_q;
  logic signed [csss_pkg::VAL_W-1:0] res_q;

  logic [csss_pkg::HALF_W-1:0]       pa, pb;
  logic [2*csss_pkg::HALF_W-1:0]     pp;
  logic [csss_pkg::PROD_W-1:0]       pp_sh, rnd, shr;
  logic                              over;
  logic [csss_pkg::MAG_W-1:0]        mag;
  logic signed [csss_pkg::VAL_W-1:0] res_d;

  always_comb begin
    pa = cnt_q[0] ? csss_pkg::HALF_W'(a_q[csss_pkg::MAG_W-1:csss_pkg::HALF_W])
                  : a_q[csss_pkg::HALF_W-1:0];
    pb = cnt_q[1] ? csss_pkg::HALF_W'(b_q[csss_pkg::MAG_W-1:csss_pkg::HALF_W])
                  : b_q[csss_pkg::HALF_W-1:0];
    pp = pa * pb;
    case (cnt_q[1:0])
      2'd0:    pp_sh = csss_pkg::PROD_W'(pp);
      2'd1,
      2'd2:    pp_sh = csss_pkg::PROD_W'(pp) << csss_pkg::HALF_W;
      default: pp_sh = csss_pkg::PROD_W'(pp) << (2 * csss_pkg::HALF_W);
    endcase
    rnd = acc_q + (sh32_q ? (csss_pkg::PROD_W'(1) << 31)
                          : (csss_pkg::PROD_W'(1) << (csss_pkg::FRAC_BITS - 1)));
    shr = sh32_q ? (rnd >> 32) : (rnd >> csss_pkg::FRAC_BITS);
    over = shr > (csss_pkg::PROD_W'(1) << csss_pkg::LIM_BITS);
    mag = over ? (csss_pkg::MAG_W'(1) << csss_pkg::LIM_BITS) : shr[csss_pkg::MAG_W-1:0];
    res_d = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 3'(csss_pkg::MUL_STEPS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q    <= csss_pkg::mag_of(req_i.a);
      b_q    <= csss_pkg::mag_of(req_i.b);
      neg_q  <= req_i.a[csss_pkg::VAL_W-1] ^ req_i.b[csss_pkg::VAL_W-1];
      sh32_q <= req_i.sh32;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == 3'(csss_pkg::MUL_STEPS)) begin
        res_q <= res_d;
        sat_q <= over;
      end else begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.res  = res_q;

endmodule

// ===== rtl/csss_div.sv =====
// Restoring divider, one quotient bit per cycle.
module csss_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csss_pkg::div_req_t req_i,
  output csss_pkg::div_rsp_t rsp_o
);

  logic [csss_pkg::DIV_W:0]       rem_q;
  logic [csss_pkg::DIV_W-1:0]     quo_q, den_q;
  logic [csss_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;

  logic [csss_pkg::DIV_W:0]       shifted, diff;
  logic                           take;

  always_comb begin
    shifted = {rem_q[csss_pkg::DIV_W-1:0], quo_q[csss_pkg::DIV_W-1]};
    take    = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == csss_pkg::DIV_CNT_W'(csss_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + csss_pkg::DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= take ? diff : shifted;
      quo_q <= {quo_q[csss_pkg::DIV_W-2:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/critically_damped_spring_step_core.sv =====
// Each item runs two divisions (61-bit quotients, damping and decay factor),
// eleven multiplies, three add steps and a write-back step; the write-back
// waits for room in the output register.
// Input is taken only while the sequencer is idle, not before the last item is written back.
// Reset (async, active low) clears position and velocity to zero, sets half-life
// to 1.0 and empties the output register.
module critically_damped_spring_step_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [csss_pkg::WORD_BITS-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  csss_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output csss_pkg::out_t                      out_data_o
);

  localparam int VW = csss_pkg::VAL_W;
  localparam int WB = csss_pkg::WORD_BITS;

  csss_pkg::state_e state_q, state_d;

  // Architectural state.
  logic [WB-1:0]        half_life_q;
  logic signed [WB-1:0] position_q, velocity_q;
  logic                 out_valid_q;
  csss_pkg::out_t       out_q;
  logic                 issued_q;

  // Scratch registers of the sequence.
  logic signed [VW-1:0]            goal_q, y_q, u_q, u2_q, u3_q, den_q, e_q;
  logic signed [VW-1:0]            j0_q, j1_q, t_q, np_q, nv_q;
  logic [csss_pkg::DT_W-1:0]       dt_q;
  logic                            sat_q;

  csss_pkg::mul_req_t mul_req;
  csss_pkg::mul_rsp_t mul_rsp;
  csss_pkg::div_req_t div_req;
  csss_pkg::div_rsp_t div_rsp;

  logic                      in_fire, wb_fire;
  logic                      post_add;
  logic signed [VW-1:0]      add_a, add_b;
  csss_pkg::sum_t            sum;
  logic signed [VW-1:0]      mul_val;
  logic                      mul_sat;
  logic [WB:0]               hl_p1;
  logic signed [VW-1:0]      dt_v, pos_v, vel_v;
  csss_pkg::word_t           wp, wv;

  csss_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  csss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_fire = in_valid_i && in_ready_o;
  assign wb_fire = (state_q == csss_pkg::ST_WB) && (!out_valid_q || out_ready_i);

  // Widen word-sized state to the working format.
  assign dt_v  = VW'(dt_q);
  assign pos_v = {{(VW - WB){position_q[WB-1]}}, position_q};
  assign vel_v = {{(VW - WB){velocity_q[WB-1]}}, velocity_q};
  assign hl_p1 = {1'b0, half_life_q} + (WB + 1)'(1);

  // Next state: multiply and divide steps wait for their unit, add steps advance unconditionally.
  always_comb begin
    state_d = state_q;
    case (state_q)
      csss_pkg::ST_IDLE: if (in_fire) state_d = csss_pkg::ST_Y;
      csss_pkg::ST_Y:    if (div_rsp.done) state_d = csss_pkg::ST_U;
      csss_pkg::ST_U:    if (mul_rsp.done) state_d = csss_pkg::ST_U2;
      csss_pkg::ST_U2:   if (mul_rsp.done) state_d = csss_pkg::ST_U3;
      csss_pkg::ST_U3:   if (mul_rsp.done) state_d = csss_pkg::ST_DEN;
      csss_pkg::ST_DEN:  state_d = csss_pkg::ST_D2;
      csss_pkg::ST_D2:   if (mul_rsp.done) state_d = csss_pkg::ST_D3;
      csss_pkg::ST_D3:   if (mul_rsp.done) state_d = csss_pkg::ST_E;
      csss_pkg::ST_E:    if (div_rsp.done) state_d = csss_pkg::ST_J0;
      csss_pkg::ST_J0:   state_d = csss_pkg::ST_J1;
      csss_pkg::ST_J1:   if (mul_rsp.done) state_d = csss_pkg::ST_T;
      csss_pkg::ST_T:    if (mul_rsp.done) state_d = csss_pkg::ST_NP;
      csss_pkg::ST_NP:   if (mul_rsp.done) state_d = csss_pkg::ST_JY;
      csss_pkg::ST_JY:   if (mul_rsp.done) state_d = csss_pkg::ST_TV;
      csss_pkg::ST_TV:   if (mul_rsp.done) state_d = csss_pkg::ST_V;
      csss_pkg::ST_V:    state_d = csss_pkg::ST_NV;
      csss_pkg::ST_NV:   if (mul_rsp.done) state_d = csss_pkg::ST_WB;
      csss_pkg::ST_WB:   if (wb_fire) state_d = csss_pkg::ST_IDLE;
      default:           state_d = csss_pkg::ST_IDLE;
    endcase
  end

  // Step outputs: operands for the shared multiplier, divider and saturating adder.
  always_comb begin
    in_ready_o    = 1'b0;
    mul_req.start = 1'b0;
    mul_req.sh32  = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    post_add      = 1'b0;
    add_a         = mul_rsp.res;
    add_b         = '0;
    case (state_q)
      csss_pkg::ST_IDLE: in_ready_o = 1'b1;
      csss_pkg::ST_Y: begin
        // y = 2 ln2 / (half-life + 1 LSB), rounded.
        div_req.start = !issued_q;
        div_req.num   = csss_pkg::NUM_Y + csss_pkg::DIV_W'(hl_p1 >> 1);
        div_req.den   = csss_pkg::DIV_W'(hl_p1);
      end
      csss_pkg::ST_U: begin
        mul_req.start = !issued_q;
        mul_req.a     = y_q;
        mul_req.b     = dt_v;
      end
      csss_pkg::ST_U2: begin
        mul_req.start = !issued_q;
        mul_req.a     = u_q;
        mul_req.b     = u_q;
      end
      csss_pkg::ST_U3: begin
        mul_req.start = !issued_q;
        mul_req.a     = u2_q;
        mul_req.b     = u_q;
      end
      csss_pkg::ST_DEN: begin
        add_a = csss_pkg::ONE_V;
        add_b = u_q;
      end
      csss_pkg::ST_D2: begin
        mul_req.start = !issued_q;
        mul_req.sh32  = 1'b1;
        mul_req.a     = u2_q;
        mul_req.b     = csss_pkg::C048_V;
        post_add      = 1'b1;
        add_b         = den_q;
      end
      csss_pkg::ST_D3: begin
        mul_req.start = !issued_q;
        mul_req.sh32  = 1'b1;
        mul_req.a     = u3_q;
        mul_req.b     = csss_pkg::C0235_V;
        post_add      = 1'b1;
        add_b         = den_q;
      end
      csss_pkg::ST_E: begin
        // Decay factor: denominator is at least one, so no zero divide.
        div_req.start = !issued_q;
        div_req.num   = csss_pkg::E_NUM + (den_q[csss_pkg::MAG_W-1:0] >> 1);
        div_req.den   = den_q[csss_pkg::MAG_W-1:0];
      end
      csss_pkg::ST_J0: begin
        add_a = pos_v;
        add_b = -goal_q;
      end
      csss_pkg::ST_J1: begin
        mul_req.start = !issued_q;
        mul_req.a     = j0_q;
        mul_req.b     = y_q;
        post_add      = 1'b1;
        add_b         = vel_v;
      end
      csss_pkg::ST_T: begin
        mul_req.start = !issued_q;
        mul_req.a     = j1_q;
        mul_req.b     = dt_v;
        post_add      = 1'b1;
        add_b         = j0_q;
      end
      csss_pkg::ST_NP: begin
        mul_req.start = !issued_q;
        mul_req.a     = e_q;
        mul_req.b     = t_q;
        post_add      = 1'b1;
        add_b         = goal_q;
      end
      csss_pkg::ST_JY: begin
        mul_req.start = !issued_q;
        mul_req.a     = j1_q;
        mul_req.b     = y_q;
      end
      csss_pkg::ST_TV: begin
        mul_req.start = !issued_q;
        mul_req.a     = t_q;
        mul_req.b     = dt_v;
      end
      csss_pkg::ST_V: begin
        add_a = vel_v;
        add_b = -t_q;
      end
      csss_pkg::ST_NV: begin
        mul_req.start = !issued_q;
        mul_req.a     = e_q;
        mul_req.b     = t_q;
      end
      default: ;
    endcase
  end

  assign sum     = csss_pkg::sadd(add_a, add_b);
  assign mul_val = post_add ? sum.val : mul_rsp.res;
  assign mul_sat = mul_rsp.sat | (post_add & sum.sat);

  // Clamp the new state to the word range at write-back.
  assign wp = csss_pkg::to_word(np_q);
  assign wv = csss_pkg::to_word(nv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csss_pkg::ST_IDLE;
      issued_q    <= 1'b0;
      half_life_q <= WB'(1) << csss_pkg::FRAC_BITS;
      position_q  <= '0;
      velocity_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Hold the unit-issued flag until that unit reports done.
      if (mul_req.start || div_req.start) begin
        issued_q <= 1'b1;
      end else if (mul_rsp.done || div_rsp.done) begin
        issued_q <= 1'b0;
      end
      if (cfg_we_i) begin
        half_life_q <= cfg_wdata_i;
      end
      if (wb_fire) begin
        position_q  <= wp.word;
        velocity_q  <= wv.word;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      out_q.new_position <= wp.word;
      out_q.new_velocity <= wv.word;
      out_q.clipped      <= sat_q | wp.sat | wv.sat;
    end
    case (state_q)
      csss_pkg::ST_IDLE: begin
        if (in_fire) begin
          goal_q <= {{(VW - WB){in_data_i.goal_position[WB-1]}}, in_data_i.goal_position};
          // Clamp the time step to one second.
          dt_q   <= (in_data_i.time_step > csss_pkg::DT_ONE) ? csss_pkg::DT_ONE
                                                             : in_data_i.time_step;
          sat_q  <= 1'b0;
        end
      end
      csss_pkg::ST_Y: if (div_rsp.done) y_q <= VW'(div_rsp.quo);
      csss_pkg::ST_E: if (div_rsp.done) e_q <= VW'(div_rsp.quo);
      csss_pkg::ST_DEN: begin
        den_q <= sum.val;
        sat_q <= sat_q | sum.sat;
      end
      csss_pkg::ST_J0: begin
        j0_q  <= sum.val;
        sat_q <= sat_q | sum.sat;
      end
      csss_pkg::ST_V: begin
        t_q   <= sum.val;
        sat_q <= sat_q | sum.sat;
      end
      default: begin
        if (mul_rsp.done) begin
          sat_q <= sat_q | mul_sat;
          case (state_q)
            csss_pkg::ST_U:  u_q  <= mul_val;
            csss_pkg::ST_U2: u2_q <= mul_val;
            csss_pkg::ST_U3: u3_q <= mul_val;
            csss_pkg::ST_D2,
            csss_pkg::ST_D3: den_q <= mul_val;
            csss_pkg::ST_J1: j1_q <= mul_val;
            csss_pkg::ST_T,
            csss_pkg::ST_JY,
            csss_pkg::ST_TV: t_q  <= mul_val;
            csss_pkg::ST_NP: np_q <= mul_val;
            csss_pkg::ST_NV: nv_q <= mul_val;
            default: ;
          endcase
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/csss_checker.sv =====
`include "critically_damped_spring_step_core_macros.svh"

module csss_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input csss_pkg::out_t out_data_o
);

  // A stalled result holds.
  `CSSS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // Busy right after taking an item.
  `CSSS_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)

  // A new result appears only at the end of a busy stretch.
  `CSSS_ASSERT_NOW(a_out_from_busy, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind critically_damped_spring_step_core csss_checker u_csss_checker (.*);

// ===== bench/tb_critically_damped_spring_step_core.sv =====
`timescale 1ns / 100ps

// Scoreboard: tracks the spring state the block should hold and the queue of
// results owed for accepted inputs.
class spring_scoreboard;
  localparam longint LIM = 64'sd1 << 60;
  localparam longint ONE = 64'sd1 << csss_pkg::FRAC_BITS;
  localparam longint unsigned TWO_LN2 = 64'd5954088944;
  localparam longint unsigned C048    = 64'd2061584302;
  localparam longint unsigned C0235   = 64'd1009317315;

  longint unsigned half_life;
  longint pos_q;
  longint vel_q;
  bit clip;
  csss_pkg::out_t owed_q[$];
  int mismatches;
  int results_seen;
  int clipped_seen;

  function void clear();
    half_life = ONE;
    pos_q = 0;
    vel_q = 0;
    owed_q.delete();
    mismatches = 0;
    results_seen = 0;
    clipped_seen = 0;
  endfunction

  // Rounded unsigned product shifted down, saturated to the internal limit.
  function longint unsigned mul_shift(longint unsigned a, longint unsigned b, int sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'(LIM)) begin
      clip = 1'b1;
      return LIM;
    end
    return p[63:0];
  endfunction

  function longint magnitude(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function longint smul(longint a, longint b, int sh);
    longint r;
    r = longint'(mul_shift(magnitude(a), magnitude(b), sh));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > LIM) begin clip = 1'b1; return LIM; end
    if (s < -LIM) begin clip = 1'b1; return -LIM; end
    return s;
  endfunction

  function longint clamp_word(longint a);
    if (a > 64'sd2147483647) begin clip = 1'b1; return 64'sd2147483647; end
    if (a < -64'sd2147483648) begin clip = 1'b1; return -64'sd2147483648; end
    return a;
  endfunction

  // Advance the spring by one step and queue the result it owes.
  function void note_transfer(csss_pkg::in_t item);
    longint goal, dt, y, u, u2, u3, den, e, j0, j1, t, np, nv;
    longint unsigned num, d;
    csss_pkg::out_t r;
    clip = 1'b0;
    goal = longint'(item.goal_position);
    dt = longint'({1'b0, item.time_step});
    if (dt > ONE) dt = ONE;
    num = mul_shift(TWO_LN2, 64'd1 << (2 * csss_pkg::FRAC_BITS), 32);
    d = half_life + 1;
    y = longint'((num + d / 2) / d);
    u = smul(y, dt, csss_pkg::FRAC_BITS);
    u2 = smul(u, u, csss_pkg::FRAC_BITS);
    u3 = smul(u2, u, csss_pkg::FRAC_BITS);
    den = sat_add(ONE, u);
    den = sat_add(den, smul(u2, C048, 32));
    den = sat_add(den, smul(u3, C0235, 32));
    e = longint'(((64'd1 << (2 * csss_pkg::FRAC_BITS)) + longint'(den) / 2) / den);
    j0 = sat_add(pos_q, -goal);
    j1 = sat_add(vel_q, smul(j0, y, csss_pkg::FRAC_BITS));
    t = sat_add(j0, smul(j1, dt, csss_pkg::FRAC_BITS));
    np = sat_add(smul(e, t, csss_pkg::FRAC_BITS), goal);
    t = smul(smul(j1, y, csss_pkg::FRAC_BITS), dt, csss_pkg::FRAC_BITS);
    nv = smul(e, sat_add(vel_q, -t), csss_pkg::FRAC_BITS);
    pos_q = clamp_word(np);
    vel_q = clamp_word(nv);
    r.new_position = pos_q[31:0];
    r.new_velocity = vel_q[31:0];
    r.clipped = clip;
    owed_q.push_back(r);
  endfunction

  function void check_result(csss_pkg::out_t got);
    csss_pkg::out_t want;
    results_seen++;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = owed_q.pop_front();
    if (want.clipped) clipped_seen++;
    if (got.new_position !== want.new_position || got.new_velocity !== want.new_velocity ||
        got.clipped !== want.clipped) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected pos %h vel %h clip %b, got pos %h vel %h clip %b",
                 results_seen, want.new_position, want.new_velocity, want.clipped,
                 got.new_position, got.new_velocity, got.clipped);
    end
  endfunction
endclass

module tb_critically_damped_spring_step_core;

  localparam int STALL_LIMIT = 20000;  // idle cycles before the watchdog fires
  localparam int SETTLE = 300;         // extra wait after the drain

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [csss_pkg::WORD_BITS-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  csss_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  csss_pkg::out_t out_data_o;

  spring_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int stall_cnt = 0;
  int items_sent = 0;

  critically_damped_spring_step_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Result side: sample the pre-edge handshake, then pick ready for the next cycle.
  // A hold request drops ready for a long counted stretch so the core backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_req && hold_left == 0) begin
        hold_left = 1500;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one input; keep valid high across back-to-back transfers.
  task automatic send_step(csss_pkg::in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(item);
    items_sent++;
  endtask

  // Drain, let the core settle, then write the half-life.
  task automatic set_half_life(logic [csss_pkg::WORD_BITS-1:0] hl);
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.half_life = hl;
  endtask

  function automatic csss_pkg::in_t make_step(logic signed [csss_pkg::WORD_BITS-1:0] g,
                                              logic [csss_pkg::DT_W-1:0] dt);
    csss_pkg::in_t s;
    s.goal_position = g;
    s.time_step = dt;
    return s;
  endfunction

  // Random step: mostly moderate goals and legal time steps, with some extremes,
  // full-range goals and time steps past one second.
  function automatic csss_pkg::in_t random_step();
    logic signed [csss_pkg::WORD_BITS-1:0] g;
    logic [csss_pkg::DT_W-1:0] dt;
    case ($urandom_range(9))
      0: g = $urandom();
      1: g = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: g = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
    endcase
    case ($urandom_range(9))
      0: dt = csss_pkg::DT_W'($urandom_range(131071, 65537));
      1: dt = $urandom_range(1) ? csss_pkg::DT_ONE : '0;
      default: dt = csss_pkg::DT_W'($urandom_range(65536));
    endcase
    return make_step(g, dt);
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_step(random_step());
  endtask

  initial begin
    logic [csss_pkg::WORD_BITS-1:0] hl;
    sb.clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: field extremes, time step clamping, zero and full-scale half-life.
    set_half_life(32'h0001_0000);
    send_step(make_step(32'sh7fffffff, csss_pkg::DT_ONE));
    send_step(make_step(32'sh80000000, csss_pkg::DT_ONE));
    send_step(make_step(32'sh80000000, 17'h1ffff));
    send_step(make_step(32'sh00010000, 17'h10001));
    send_step(make_step(32'sh7fffffff, '0));
    send_step(make_step('0, 17'h0ffff));
    send_step(make_step(32'shffff0000, 17'h00001));
    send_step(make_step(32'sh55555555, 17'h0aaaa));
    send_step(make_step(32'shaaaaaaaa, 17'h15555));
    set_half_life('0);
    send_step(make_step(32'sh7fffffff, csss_pkg::DT_ONE));
    send_step(make_step(32'sh80000000, 17'h00001));
    send_step(make_step(32'sh00020000, 17'h08000));
    send_step(make_step(32'sh7fffffff, 17'h1ffff));
    set_half_life(32'hffffffff);
    send_step(make_step(32'sh80000000, csss_pkg::DT_ONE));
    send_step(make_step(32'sh7fffffff, 17'h1ffff));
    send_step(make_step(32'sh00010000, 17'h00100));

    // Random phases across half-lives and idle patterns; sender 23/receiver 63 first.
    send_idle_pct = 23;
    recv_idle_pct = 63;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 23;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph % 4)
        0: hl = $urandom_range(32'h0004_0000, 32'h0000_1000);
        1: hl = $urandom_range(3);
        2: hl = $urandom();
        default: hl = $urandom_range(1) ? 32'hffffffff : 32'h0000_8000;
      endcase
      set_half_life(hl);
      // Back the result side up while inputs keep coming.
      if (ph == 7) hold_req = 1'b1;
      random_burst(125);
    end

    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("Ran %0d spring steps over 12 half-life settings; %0d results, %0d saturated.",
             items_sent, sb.results_seen, sb.clipped_seen);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/csss_pkg.sv
rtl/csss_mul.sv
rtl/csss_div.sv
rtl/critically_damped_spring_step_core.sv
rtl/csss_checker.sv
bench/tb_critically_damped_spring_step_core.sv
